/* hw/rtl/ptt_pkg.sv */
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int unsigned DUR_W = 15;
  localparam int unsigned DIV_W = 8;
  localparam int unsigned SYM_W = 32;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Input item commands
  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PTR_RST = 3'd1;
  localparam logic [MODE_W-1:0] MODE_START   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLR_END = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_DIVIDER      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_OUTPUT_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL         = 2'd2;

  localparam logic [DIV_W-1:0] CLOCK_DIVIDER_RST = 8'd2;

  typedef logic [SYM_W-1:0] sym_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DUR_W-1:0]  first_duration;
    logic              first_level;
    logic [DUR_W-1:0]  second_duration;
    logic              second_level;
  } in_item_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic end_flag;
    logic overflow;
  } out_item_t;

endpackage

/* hw/rtl/ptt_symbol_mem.sv */
`timescale 1ns / 1ps

module ptt_symbol_mem
  import ptt_pkg::*;
#(
  parameter int unsigned DEPTH = 48,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  sym_t              wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output sym_t              rd_data
);

  sym_t mem [DEPTH];
  sym_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Pass a same-cycle write through so the read word never goes stale
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/ptt_out_buf.sv */
`timescale 1ns / 1ps

module ptt_out_buf
  import ptt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t skid_data_r, skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        if (push) begin
          out_data_nxt = push_data;
        end
      end
    end else if (push) begin
      // park the item while the output stalls
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/pulse_train_transmitter.sv */
`timescale 1ns / 1ps

// One-channel pulse train transmitter. Each input item is one command: write a
// symbol, reset the write pointer, start a run, one source clock tick, or clear
// the end flag; each item yields exactly one status item (pin level, busy, end
// flag, overflow) reflecting the state after the command. The block takes one
// item per clock cycle while in_ready is high, and its status item is registered
// in the output register, or parked in a skid register while the output side
// stalls; this two-entry output buffer takes one more item while the output side
// stalls, after which in_ready drops until the output side takes an item. Symbols
// sit in a memory of MEM_SYMBOLS words with one write port and one registered read
// port; the word after the one being played is fetched ahead into a register, and
// entry 0 is mirrored in a register so that a start needs no memory read.
module pulse_train_transmitter
  import ptt_pkg::*;
#(
  parameter int unsigned MEM_SYMBOLS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(MEM_SYMBOLS);
  localparam int unsigned CNT_W = $clog2(MEM_SYMBOLS + 1);

  // Configuration
  logic [DIV_W-1:0] clock_divider_r;
  logic             idle_output_enable_r;
  logic             idle_level_r;

  // Channel state
  logic [CNT_W-1:0] wi_r, wi_nxt;
  logic [CNT_W-1:0] ri_r, ri_nxt;
  logic             half_r, half_nxt;
  logic [DUR_W-1:0] tick_r, tick_nxt;
  logic [DIV_W-1:0] pre_r, pre_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  sym_t             cur_word_r, cur_word_nxt;
  sym_t             word0_r, word0_nxt;

  logic             accept;
  logic             push_ready;
  logic             wr_en;
  sym_t             wr_word;
  sym_t             next_word;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W:0]   ri_inc;
  logic [DIV_W:0]   div_full;
  logic [DIV_W:0]   pre_inc;
  logic [DUR_W-1:0] tick_dec;
  logic [DUR_W-1:0] load_d;
  logic             load_chk;
  logic             fin;
  logic             ovf;
  out_item_t        res;

  assign accept   = in_valid && push_ready;
  assign in_ready = push_ready;

  assign wr_word = {in_item.second_level, in_item.second_duration,
                    in_item.first_level, in_item.first_duration};

  assign ri_inc   = {1'b0, ri_r} + {{CNT_W{1'b0}}, 1'b1};
  assign rd_addr  = (ri_inc < (CNT_W + 1)'(MEM_SYMBOLS)) ? ri_inc[ADDR_W-1:0] : '0;
  assign div_full = (clock_divider_r == '0) ? (DIV_W + 1)'(1 << DIV_W)
                                            : {1'b0, clock_divider_r};
  assign pre_inc  = {1'b0, pre_r} + {{DIV_W{1'b0}}, 1'b1};
  assign tick_dec = tick_r - {{(DUR_W - 1){1'b0}}, 1'b1};

  ptt_symbol_mem #(
    .DEPTH  (MEM_SYMBOLS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wi_r[ADDR_W-1:0]),
    .wr_data (wr_word),
    .rd_addr (rd_addr),
    .rd_data (next_word)
  );

  always_comb begin
    wi_nxt       = wi_r;
    ri_nxt       = ri_r;
    half_nxt     = half_r;
    tick_nxt     = tick_r;
    pre_nxt      = pre_r;
    run_nxt      = run_r;
    done_nxt     = done_r;
    cur_word_nxt = cur_word_r;
    word0_nxt    = word0_r;
    wr_en        = 1'b0;
    ovf          = 1'b0;
    fin          = 1'b0;
    load_chk     = 1'b0;
    load_d       = '0;
    unique case (in_item.mode)
      MODE_WRITE: begin
        if (wi_r < CNT_W'(MEM_SYMBOLS)) begin
          wr_en  = accept;
          wi_nxt = wi_r + {{(CNT_W - 1){1'b0}}, 1'b1};
          // keep the mirrored words equal to their memory entries
          if (wi_r == ri_r) begin
            cur_word_nxt = wr_word;
          end
          if (wi_r == '0) begin
            word0_nxt = wr_word;
          end
        end else begin
          ovf = 1'b1;
        end
      end
      MODE_PTR_RST: begin
        wi_nxt = '0;
      end
      MODE_START: begin
        run_nxt      = 1'b1;
        pre_nxt      = '0;
        ri_nxt       = '0;
        half_nxt     = 1'b0;
        cur_word_nxt = word0_r;
        if (wi_r == '0) begin
          fin = 1'b1;
        end else begin
          load_chk = 1'b1;
          load_d   = word0_r[DUR_W-1:0];
        end
      end
      MODE_TICK: begin
        if (run_r) begin
          if (pre_inc >= div_full) begin
            pre_nxt = '0;
            if (tick_dec != '0) begin
              tick_nxt = tick_dec;
            end else if (!half_r) begin
              half_nxt = 1'b1;
              load_chk = 1'b1;
              load_d   = cur_word_r[2*DUR_W:DUR_W+1];
            end else begin
              // advance to the prefetched symbol
              ri_nxt       = ri_inc[CNT_W-1:0];
              half_nxt     = 1'b0;
              cur_word_nxt = next_word;
              if (ri_inc >= {1'b0, wi_r}) begin
                fin = 1'b1;
              end else begin
                load_chk = 1'b1;
                load_d   = next_word[DUR_W-1:0];
              end
            end
          end else begin
            pre_nxt = pre_inc[DIV_W-1:0];
          end
        end
      end
      MODE_CLR_END: begin
        done_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    if (load_chk) begin
      if (load_d == '0) begin
        fin = 1'b1;
      end else begin
        tick_nxt = load_d;
      end
    end
    if (fin) begin
      run_nxt  = 1'b0;
      done_nxt = 1'b1;
      pre_nxt  = '0;
      tick_nxt = '0;
      half_nxt = 1'b0;
    end
    res.busy_res  = run_nxt;
    res.end_flag  = done_nxt;
    res.overflow  = ovf;
    if (run_nxt) begin
      res.pin_level = half_nxt ? cur_word_nxt[SYM_W-1] : cur_word_nxt[DUR_W];
    end else begin
      res.pin_level = idle_output_enable_r & idle_level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r   <= '0;
      ri_r   <= '0;
      half_r <= 1'b0;
      tick_r <= '0;
      pre_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (accept) begin
      wi_r   <= wi_nxt;
      ri_r   <= ri_nxt;
      half_r <= half_nxt;
      tick_r <= tick_nxt;
      pre_r  <= pre_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_word_r <= cur_word_nxt;
      word0_r    <= word0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_divider_r      <= CLOCK_DIVIDER_RST;
      idle_output_enable_r <= 1'b0;
      idle_level_r         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLOCK_DIVIDER:      clock_divider_r      <= cfg_wdata;
        CFG_IDLE_OUTPUT_ENABLE: idle_output_enable_r <= cfg_wdata[0];
        CFG_IDLE_LEVEL:         idle_level_r         <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  ptt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .can_push  (push_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_item)
  );

endmodule
